// File: rtl/rkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared widths and constants of the rsa key derivation block.
// ----------------------------------------------------------------------------
package rkd_pkg;

  // transaction field widths
  localparam int unsigned PRIME_W = 32;
  localparam int unsigned OUT_W   = 64;
  localparam int unsigned EXP_W   = 32;

  // default factor width used by the arithmetic
  localparam int unsigned PRIME_BITS_DEF = 32;

  // public exponent after reset
  localparam logic [EXP_W-1:0] EXP_RESET = 32'd65537;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_INV = 1'b1;

endpackage

// File: rtl/rkd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_in_if
// Input channel: one pair of prime factors per transaction.
// ----------------------------------------------------------------------------
interface rkd_in_if;

  logic                         valid;
  logic                         ready;
  logic [rkd_pkg::PRIME_W-1:0]  prime_p;
  logic [rkd_pkg::PRIME_W-1:0]  prime_q;

  modport source (output valid, output prime_p, output prime_q, input ready);
  modport sink   (input valid, input prime_p, input prime_q, output ready);

endinterface

// File: rtl/rkd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_out_if
// Result channel: modulus, private exponent and status per transaction.
// ----------------------------------------------------------------------------
interface rkd_out_if;

  logic                       valid;
  logic                       ready;
  logic [rkd_pkg::OUT_W-1:0]  modulus_n;
  logic [rkd_pkg::OUT_W-1:0]  private_exponent;
  logic                       status;

  modport source (output valid, output modulus_n, output private_exponent,
                  output status, input ready);
  modport sink   (input valid, input modulus_n, input private_exponent,
                  input status, output ready);

endinterface

// File: rtl/rsa_key_derivation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_key_derivation_top
// RSA key derivation: n = p*q and d = e^-1 mod (p-1)(q-1).
// ----------------------------------------------------------------------------
// Usage
//   in_i carries prime_p / prime_q (low PRIME_BITS bits used); a transaction
//   is taken when valid and ready are high at a rising edge of clk_i.
//   out_o returns modulus_n, private_exponent and status (1 = no inverse,
//   exponent then zero). cfg_we_i / cfg_wdata_i write the public exponent;
//   write it only while the block is idle.
//   Sequence: n, then phi, on the one shared PRIME_BITS x PRIME_BITS
//   multiplier, a set-up state, then the extended Euclid on a single
//   shared subtract/compare unit of max(2*PRIME_BITS, 32) bits: each Euclid
//   step aligns the divisor, then develops its quotient bit by bit, and a
//   final state loads the result. Small factors finish sooner than large
//   ones; one transaction is in flight at a time, and the next is taken
//   only once the sequencer is back in idle.
//   Reset clears the sequencer and the output valid and loads e = 65537.
//   The result sits in an output register; a new transaction may be taken
//   while it waits. If the receiver stalls, the next result holds in the
//   final state until the output register is free.
// ----------------------------------------------------------------------------
module rsa_key_derivation_top #(
  parameter int unsigned PRIME_BITS = rkd_pkg::PRIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rkd_pkg::EXP_W-1:0]   cfg_wdata_i,
  rkd_in_if.sink                      in_i,
  rkd_out_if.source                   out_o
);

  localparam int unsigned PW  = PRIME_BITS;
  localparam int unsigned NW  = 2 * PRIME_BITS;
  localparam int unsigned EW  = (NW > rkd_pkg::EXP_W) ? NW : rkd_pkg::EXP_W;
  localparam int unsigned KW  = $clog2(EW);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_N   = 3'd1;
  localparam logic [2:0] ST_MUL_PHI = 3'd2;
  localparam logic [2:0] ST_INIT    = 3'd3;
  localparam logic [2:0] ST_ALIGN   = 3'd4;
  localparam logic [2:0] ST_SUB     = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [rkd_pkg::EXP_W-1:0] exp_q;
  logic [PW-1:0]             p_q, p_d, q_q, q_d;
  logic [NW-1:0]             n_q, n_d, phi_q, phi_d;
  logic                      bad_q, bad_d, fail_q, fail_d;
  logic [EW-1:0]             r0_q, r0_d, r1s_q, r1s_d;
  logic [EW-1:0]             t0_q, t0_d, t1s_q, t1s_d;
  logic                      neg_q, neg_d;
  logic [KW-1:0]             k_q, k_d;
  logic                      out_valid_q;
  logic [rkd_pkg::OUT_W-1:0] out_n_q, out_d_q;
  logic                      out_status_q;

  logic [PW-1:0]             mul_a, mul_b;
  logic [NW-1:0]             prod;
  logic [EW-1:0]             sub_a, sub_b, t_sum, res_d;
  logic [EW:0]               diff;
  logic                      ge, in_acc, slot_free, load_out, res_err;

  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign load_out  = (state_q == ST_FIN) && slot_free;

  // shared multiplier: n first, then phi
  assign mul_a = (state_q == ST_MUL_N) ? p_q : p_q - PW'(1);
  assign mul_b = (state_q == ST_MUL_N) ? q_q : q_q - PW'(1);
  assign prod  = NW'(mul_a) * NW'(mul_b);

  // shared subtract/compare unit
  always_comb begin
    case (state_q)
      ST_ALIGN: begin
        sub_a = r0_q;
        sub_b = {r1s_q[EW-2:0], 1'b0};
      end
      ST_FIN: begin
        sub_a = EW'(phi_q);
        sub_b = t0_q;
      end
      default: begin
        sub_a = r0_q;
        sub_b = r1s_q;
      end
    endcase
  end
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = !diff[EW];
  assign t_sum = t0_q + t1s_q;

  // final result: t0 is negative when the last sign flag is clear
  assign res_err = fail_q || (r0_q != EW'(1));
  always_comb begin
    if (res_err) begin
      res_d = '0;
    end else if (!neg_q && (t0_q != '0)) begin
      res_d = diff[EW-1:0];
    end else begin
      res_d = t0_q;
    end
  end

  // sequencer and datapath
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    n_d     = n_q;
    phi_d   = phi_q;
    bad_d   = bad_q;
    fail_d  = fail_q;
    r0_d    = r0_q;
    r1s_d   = r1s_q;
    t0_d    = t0_q;
    t1s_d   = t1s_q;
    neg_d   = neg_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          p_d     = in_i.prime_p[PW-1:0];
          q_d     = in_i.prime_q[PW-1:0];
          state_d = ST_MUL_N;
        end
      end
      ST_MUL_N: begin
        n_d     = prod;
        state_d = ST_MUL_PHI;
      end
      ST_MUL_PHI: begin
        phi_d   = prod;
        bad_d   = (p_q < PW'(2)) || (q_q < PW'(2));
        state_d = ST_INIT;
      end
      ST_INIT: begin
        r0_d   = EW'(phi_q);
        r1s_d  = EW'(exp_q);
        t0_d   = '0;
        t1s_d  = EW'(1);
        neg_d  = 1'b0;
        k_d    = '0;
        fail_d = bad_q || (phi_q < NW'(2)) || (exp_q == '0);
        state_d = fail_d ? ST_FIN : ST_ALIGN;
      end
      ST_ALIGN: begin
        // scale divisor and coefficient up to the top quotient bit
        if (!r1s_q[EW-1] && ge) begin
          r1s_d = {r1s_q[EW-2:0], 1'b0};
          t1s_d = {t1s_q[EW-2:0], 1'b0};
          k_d   = k_q + KW'(1);
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        // one quotient bit per cycle
        if (ge) begin
          r0_d = diff[EW-1:0];
          t0_d = t_sum;
        end
        if (k_q == '0) begin
          // step complete: rotate remainders and coefficients
          r0_d  = r1s_q;
          r1s_d = ge ? diff[EW-1:0] : r0_q;
          t0_d  = t1s_q;
          t1s_d = ge ? t_sum : t0_q;
          neg_d = !neg_q;
          state_d = (r1s_d == '0) ? ST_FIN : ST_ALIGN;
        end else begin
          r1s_d = {1'b0, r1s_q[EW-1:1]};
          t1s_d = {1'b0, t1s_q[EW-1:1]};
          k_d   = k_q - KW'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      exp_q       <= rkd_pkg::EXP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    q_q    <= q_d;
    n_q    <= n_d;
    phi_q  <= phi_d;
    bad_q  <= bad_d;
    fail_q <= fail_d;
    r0_q   <= r0_d;
    r1s_q  <= r1s_d;
    t0_q   <= t0_d;
    t1s_q  <= t1s_d;
    neg_q  <= neg_d;
    if (load_out) begin
      out_n_q      <= rkd_pkg::OUT_W'(n_q);
      out_d_q      <= rkd_pkg::OUT_W'(res_d);
      out_status_q <= res_err ? rkd_pkg::STATUS_NO_INV : rkd_pkg::STATUS_OK;
    end
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.modulus_n        = out_n_q;
  assign out_o.private_exponent = out_d_q;
  assign out_o.status           = out_status_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == rkd_pkg::STATUS_NO_INV)) |-> (out_d_q == '0))
    else $error("error result with non-zero exponent");

  a_d_below_phi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !res_err) |-> (res_d < EW'(phi_q)))
    else $error("private exponent not reduced modulo phi");

  a_idle_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (k_q == '0))
    else $error("shift count left over at idle");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MUL_N))
    else $error("accepted transaction did not start");

endmodule
